@@ rtl/core/isl_pkg.sv @@
// ----------------------------------------------------------------------------
// isl_pkg
// Shared constants, command codes and the cell control word for the
// indexed shift list store.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int CMD_W  = 4;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_INSERT     = 4'd2,
    CMD_ERASE      = 4'd3,
    CMD_POP_BACK   = 4'd4,
    CMD_POP_FRONT  = 4'd5,
    CMD_READ       = 4'd6,
    CMD_CHANGE     = 4'd7,
    CMD_CLEAR      = 4'd8,
    CMD_FRONT      = 4'd9,
    CMD_BACK       = 4'd10
  } cmd_e;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              wr;
    logic              rd_en;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  rd_pos;
    logic [ELEM_W-1:0] value;
  } ctl_t;

endpackage

@@ rtl/core/isl_if.sv @@
// ----------------------------------------------------------------------------
// isl_cmd_if / isl_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface isl_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [isl_pkg::CMD_W-1:0]  cmd;
  logic [isl_pkg::POS_W-1:0]  position;
  logic [isl_pkg::VAL_W-1:0]  value_in;

  modport source (output valid, output cmd, output position, output value_in,
                  input ready);
  modport sink   (input valid, input cmd, input position, input value_in,
                  output ready);
endinterface

interface isl_res_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [isl_pkg::VAL_W-1:0]  value_out;
  logic [isl_pkg::LEN_W-1:0]  length;
  logic                       is_empty;

  modport source (output valid, output ok, output value_out, output length,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input value_out, input length,
                  input is_empty, output ready);
endinterface

@@ rtl/core/isl_cell.sv @@
// ----------------------------------------------------------------------------
// isl_cell
// One slot of the list: holds an element, shifts in from a neighbor on
// insert or erase, loads a new value, and offers its element for a read.
// ----------------------------------------------------------------------------
module isl_cell (
  input  logic                         clk_i,
  input  logic [isl_pkg::CNT_W-1:0]    idx_i,
  input  isl_pkg::ctl_t                ctl_i,
  input  logic [isl_pkg::ELEM_W-1:0]   left_i,
  input  logic [isl_pkg::ELEM_W-1:0]   right_i,
  output logic [isl_pkg::ELEM_W-1:0]   data_o,
  output logic [isl_pkg::ELEM_W-1:0]   rd_o
);

  logic [isl_pkg::ELEM_W-1:0] data_q, data_d;
  logic [isl_pkg::CNT_W-1:0]  idx_next;

  assign idx_next = idx_i + isl_pkg::CNT_W'(1);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      // open a gap at pos, tail moves up one place
      if (idx_i == ctl_i.pos) begin
        data_d = ctl_i.value;
      end else if (idx_i > ctl_i.pos && idx_i <= ctl_i.fill) begin
        data_d = left_i;
      end
    end else if (ctl_i.del) begin
      // close the gap at pos, tail moves down one place
      if (idx_i >= ctl_i.pos && idx_next < ctl_i.fill) begin
        data_d = right_i;
      end
    end else if (ctl_i.wr && idx_i == ctl_i.pos) begin
      data_d = ctl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (ctl_i.rd_en && idx_i == ctl_i.rd_pos) ? data_q : '0;

endmodule

@@ rtl/core/indexed_shift_list_store.sv @@
// ----------------------------------------------------------------------------
// indexed_shift_list_store
// Ordered list of up to DEPTH elements held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Takes one command word per clock and returns one result word for each from
// an output register, in the cycle after it is accepted; a new command is
// taken in the same cycle that the previous result is taken, so that rate
// holds while results are taken. Insert and erase move the whole tail at
// once, as every cell loads from its neighbor in parallel. A push or insert
// on a full list, and a pop, erase, front or back on an empty one, answer
// ok 0. Insert past the end appends; erase past the end drops the last
// element. value_out is zero unless a read, front or back succeeds.
// ----------------------------------------------------------------------------
module indexed_shift_list_store (
  input  logic         clk_i,
  input  logic         rst_ni,
  isl_cmd_if.sink      in_i,
  isl_res_if.source    out_o
);

  localparam int CW = isl_pkg::CNT_W;

  logic [CW-1:0]             fill_q, fill_d;
  logic                      out_valid_q;
  logic                      ok_q;
  logic [isl_pkg::VAL_W-1:0] val_q;
  logic [isl_pkg::LEN_W-1:0] len_q;
  logic                      empty_q;

  logic                      accept;
  logic                      full, empty;
  logic [CW-1:0]             pos_ext, last;
  logic                      ins, del, wr, rd_en, ok;
  logic [CW-1:0]             op_pos, rd_pos;
  isl_pkg::cmd_e             cmd;
  isl_pkg::ctl_t             ctl;
  logic [isl_pkg::ELEM_W-1:0] rd_data;

  logic [isl_pkg::ELEM_W-1:0] cell_data [isl_pkg::DEPTH];
  logic [isl_pkg::ELEM_W-1:0] cell_rd   [isl_pkg::DEPTH];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign full    = (fill_q == CW'(isl_pkg::DEPTH));
  assign empty   = (fill_q == '0);
  assign pos_ext = CW'(in_i.position);
  assign last    = fill_q - CW'(1);
  assign cmd     = isl_pkg::cmd_e'(in_i.cmd);

  always_comb begin
    ins    = 1'b0;
    del    = 1'b0;
    wr     = 1'b0;
    rd_en  = 1'b0;
    ok     = 1'b0;
    op_pos = '0;
    rd_pos = '0;
    fill_d = fill_q;
    unique case (cmd)
      isl_pkg::CMD_PUSH_BACK, isl_pkg::CMD_PUSH_FRONT, isl_pkg::CMD_INSERT: begin
        if (!full) begin
          ins    = 1'b1;
          ok     = 1'b1;
          fill_d = fill_q + CW'(1);
        end
        if (cmd == isl_pkg::CMD_PUSH_BACK) begin
          op_pos = fill_q;
        end else if (cmd == isl_pkg::CMD_INSERT) begin
          op_pos = (pos_ext > fill_q) ? fill_q : pos_ext;
        end
      end
      isl_pkg::CMD_ERASE, isl_pkg::CMD_POP_BACK, isl_pkg::CMD_POP_FRONT: begin
        if (!empty) begin
          del    = 1'b1;
          ok     = 1'b1;
          fill_d = last;
        end
        if (cmd == isl_pkg::CMD_POP_BACK) begin
          op_pos = last;
        end else if (cmd == isl_pkg::CMD_ERASE) begin
          op_pos = (pos_ext >= fill_q) ? last : pos_ext;
        end
      end
      isl_pkg::CMD_READ: begin
        if (pos_ext < fill_q) begin
          ok     = 1'b1;
          rd_en  = 1'b1;
          rd_pos = pos_ext;
        end
      end
      isl_pkg::CMD_CHANGE: begin
        op_pos = pos_ext;
        if (pos_ext < fill_q) begin
          ok = 1'b1;
          wr = 1'b1;
        end
      end
      isl_pkg::CMD_CLEAR: begin
        ok     = 1'b1;
        fill_d = '0;
      end
      isl_pkg::CMD_FRONT: begin
        if (!empty) begin
          ok    = 1'b1;
          rd_en = 1'b1;
        end
      end
      isl_pkg::CMD_BACK: begin
        if (!empty) begin
          ok     = 1'b1;
          rd_en  = 1'b1;
          rd_pos = last;
        end
      end
      default: begin
      end
    endcase
  end

  // only accepted words touch the cells
  always_comb begin
    ctl.ins    = ins && accept;
    ctl.del    = del && accept;
    ctl.wr     = wr && accept;
    ctl.rd_en  = rd_en;
    ctl.pos    = op_pos;
    ctl.fill   = fill_q;
    ctl.rd_pos = rd_pos;
    ctl.value  = isl_pkg::ELEM_W'(in_i.value_in);
  end

  for (genvar i = 0; i < isl_pkg::DEPTH; i++) begin : g_cell
    logic [isl_pkg::ELEM_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == isl_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    isl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CW'(i)),
      .ctl_i   (ctl),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // cells not selected drive zero
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < isl_pkg::DEPTH; k++) begin
      rd_data = rd_data | cell_rd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok;
      val_q   <= isl_pkg::VAL_W'(rd_data);
      len_q   <= isl_pkg::LEN_W'(fill_d);
      empty_q <= (fill_d == '0);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ok        = ok_q;
  assign out_o.value_out = val_q;
  assign out_o.length    = len_q;
  assign out_o.is_empty  = empty_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(isl_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_len_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (CW'(len_q) == fill_q))
    else $error("reported length differs from fill count");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == isl_pkg::CMD_PUSH_BACK && !full)
      |=> (fill_q == $past(fill_q) + CW'(1)))
    else $error("push did not grow the list");

  a_full_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (cmd == isl_pkg::CMD_PUSH_BACK ||
      cmd == isl_pkg::CMD_PUSH_FRONT || cmd == isl_pkg::CMD_INSERT))
      |=> (!ok_q && $stable(fill_q)))
    else $error("put on full list not rejected");

endmodule

@@ dv/indexed_shift_list_store_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_list_store_tb
// Self-checking bench for the indexed shift list store.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty-list rejections, bad
// indexes, past-the-end insert and erase, unknown codes and clear. Random
// phases then grow the list to full, drain it, and mix all commands. Every
// accepted command is run through a local list model. Every result word is
// compared field by field with the oldest expected word. Both channels idle
// at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module indexed_shift_list_store_tb;

  localparam int                        N_RANDOM    = 550;
  localparam int                        PHASE_LEN   = 50;
  localparam int                        QUIET_LIMIT = 400;
  localparam logic [isl_pkg::CMD_W-1:0] CMD_RSVD_LO = 4'd11;
  localparam logic [isl_pkg::CMD_W-1:0] CMD_RSVD_HI = 4'd15;

  typedef struct packed {
    logic                      ok;
    logic [isl_pkg::VAL_W-1:0] value;
    logic [isl_pkg::LEN_W-1:0] length;
    logic                      empty;
  } outcome_t;

  typedef struct {
    logic [isl_pkg::CMD_W-1:0] cmd;
    logic [isl_pkg::POS_W-1:0] pos;
    logic [isl_pkg::VAL_W-1:0] val;
    bit                        typed;
    outcome_t                  exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  isl_cmd_if cmd_if ();
  isl_res_if res_if ();

  indexed_shift_list_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // List model
  logic [isl_pkg::ELEM_W-1:0] slot_mem [isl_pkg::DEPTH];
  logic [isl_pkg::LEN_W-1:0]  held;

  outcome_t   expected_q [$];
  row_t       plan [$];
  bit         word_typed;
  outcome_t   word_exp;
  logic [isl_pkg::LEN_W-1:0] len_hint;

  int n_sent, n_taken, n_results, n_errors;
  int n_full_rej, n_empty_rej, peak_len, quiet;

  function automatic outcome_t outcome(logic ok, logic [isl_pkg::VAL_W-1:0] value,
                                       logic [isl_pkg::LEN_W-1:0] length, logic empty);
    outcome_t o;
    o.ok     = ok;
    o.value  = value;
    o.length = length;
    o.empty  = empty;
    return o;
  endfunction

  function automatic outcome_t apply_cmd(logic [isl_pkg::CMD_W-1:0] c,
                                         logic [isl_pkg::POS_W-1:0] p,
                                         logic [isl_pkg::VAL_W-1:0] v);
    outcome_t o;
    int       at;
    int       i;
    o = '0;
    case (isl_pkg::cmd_e'(c))
      isl_pkg::CMD_PUSH_BACK, isl_pkg::CMD_PUSH_FRONT, isl_pkg::CMD_INSERT: begin
        if (isl_pkg::cmd_e'(c) == isl_pkg::CMD_PUSH_BACK) at = held;
        else if (isl_pkg::cmd_e'(c) == isl_pkg::CMD_PUSH_FRONT) at = 0;
        else at = (p > held) ? held : p;
        if (held < isl_pkg::DEPTH) begin
          // shift the tail up one place
          for (i = held; i > at; i--) slot_mem[i] = slot_mem[i-1];
          slot_mem[at] = v[isl_pkg::ELEM_W-1:0];
          held = held + 1'b1;
          o.ok = 1'b1;
        end else begin
          n_full_rej++;
        end
      end
      isl_pkg::CMD_ERASE, isl_pkg::CMD_POP_BACK, isl_pkg::CMD_POP_FRONT: begin
        if (held == 0) begin
          n_empty_rej++;
        end else begin
          if (isl_pkg::cmd_e'(c) == isl_pkg::CMD_POP_BACK) at = held - 1;
          else if (isl_pkg::cmd_e'(c) == isl_pkg::CMD_POP_FRONT) at = 0;
          else at = (p >= held) ? held - 1 : p;
          for (i = at; i + 1 < held; i++) slot_mem[i] = slot_mem[i+1];
          held = held - 1'b1;
          o.ok = 1'b1;
        end
      end
      isl_pkg::CMD_READ: begin
        if (p < held) begin
          o.value = slot_mem[p];
          o.ok    = 1'b1;
        end
      end
      isl_pkg::CMD_CHANGE: begin
        if (p < held) begin
          slot_mem[p] = v[isl_pkg::ELEM_W-1:0];
          o.ok        = 1'b1;
        end
      end
      isl_pkg::CMD_CLEAR: begin
        held = '0;
        o.ok = 1'b1;
      end
      isl_pkg::CMD_FRONT: begin
        if (held > 0) begin
          o.value = slot_mem[0];
          o.ok    = 1'b1;
        end else begin
          n_empty_rej++;
        end
      end
      isl_pkg::CMD_BACK: begin
        if (held > 0) begin
          o.value = slot_mem[held-1];
          o.ok    = 1'b1;
        end else begin
          n_empty_rej++;
        end
      end
      default: ;
    endcase
    o.length = held;
    o.empty  = (held == 0);
    if (held > peak_len) peak_len = held;
    return o;
  endfunction

  // Predict on command words, check result words, watch for a hang.
  always @(posedge clk_i) begin
    outcome_t pred;
    outcome_t want;
    bit       moved;
    moved = 1'b0;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      pred = apply_cmd(cmd_if.cmd, cmd_if.position, cmd_if.value_in);
      expected_q.push_back(word_typed ? word_exp : pred);
      len_hint <= pred.length;
      n_taken++;
      moved = 1'b1;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      moved = 1'b1;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected: ok=%0b value=%h length=%0d empty=%0b",
                 $time, res_if.ok, res_if.value_out, res_if.length, res_if.is_empty);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (res_if.ok !== want.ok) begin
          $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, res_if.ok);
          n_errors++;
        end
        if (res_if.value_out !== want.value) begin
          $display("%0t: value_out mismatch: expected %h, actual %h",
                   $time, want.value, res_if.value_out);
          n_errors++;
        end
        if (res_if.length !== want.length) begin
          $display("%0t: length mismatch: expected %0d, actual %0d",
                   $time, want.length, res_if.length);
          n_errors++;
        end
        if (res_if.is_empty !== want.empty) begin
          $display("%0t: is_empty mismatch: expected %0b, actual %0b",
                   $time, want.empty, res_if.is_empty);
          n_errors++;
        end
      end
    end
    quiet = moved ? 0 : quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_row(logic [isl_pkg::CMD_W-1:0] c, logic [isl_pkg::POS_W-1:0] p,
                         logic [isl_pkg::VAL_W-1:0] v, bit typed, outcome_t exp);
    row_t r;
    r.cmd   = c;
    r.pos   = p;
    r.val   = v;
    r.typed = typed;
    r.exp   = exp;
    plan.push_back(r);
  endtask

  // Present one command word after a gap and hold it until taken.
  task automatic send_word(logic [isl_pkg::CMD_W-1:0] c, logic [isl_pkg::POS_W-1:0] p,
                           logic [isl_pkg::VAL_W-1:0] v, bit typed, outcome_t exp,
                           int gap);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.cmd      <= c;
    cmd_if.position <= p;
    cmd_if.value_in <= v;
    word_typed      <= typed;
    word_exp        <= exp;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  // Result side: random stalls, with stretches at full rate.
  initial begin
    int  gap;
    int  left;
    bit  burst;
    left  = 0;
    burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (left == 0) begin
        left  = $urandom_range(8, 40);
        burst = ($urandom_range(0, 3) == 0);
      end
      left--;
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  initial begin
    int                        add_pct [11];
    int                        del_pct [11];
    int                        ph;
    int                        r;
    int                        gap;
    bit                        burst;
    logic [isl_pkg::CMD_W-1:0] c;
    logic [isl_pkg::POS_W-1:0] p;
    outcome_t                  none;
    outcome_t                  idle0;

    add_pct = '{75, 75, 75, 40, 15, 15, 75, 75, 75, 40, 15};
    del_pct = '{15, 15, 15, 30, 60, 60, 15, 15, 15, 30, 60};

    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.cmd      = '0;
    cmd_if.position = '0;
    cmd_if.value_in = '0;
    res_if.ready    = 1'b0;
    word_typed      = 1'b0;
    word_exp        = '0;
    len_hint        = '0;
    held            = '0;
    n_sent = 0; n_taken = 0; n_results = 0; n_errors = 0;
    n_full_rej = 0; n_empty_rej = 0; peak_len = 0; quiet = 0;
    for (int i = 0; i < isl_pkg::DEPTH; i++) slot_mem[i] = '0;

    none  = '0;
    idle0 = outcome(1'b0, '0, 7'd0, 1'b1);

    // Rejections on an empty list first, then a small list of five.
    add_row(isl_pkg::CMD_FRONT,      6'd0,  32'h0,        1, idle0);
    add_row(isl_pkg::CMD_BACK,       6'd0,  32'h0,        1, idle0);
    add_row(isl_pkg::CMD_POP_BACK,   6'd0,  32'h0,        1, idle0);
    add_row(isl_pkg::CMD_POP_FRONT,  6'd0,  32'h0,        1, idle0);
    add_row(isl_pkg::CMD_ERASE,      6'd0,  32'h0,        1, idle0);
    add_row(isl_pkg::CMD_READ,       6'd0,  32'h0,        1, idle0);
    add_row(isl_pkg::CMD_CHANGE,     6'd0,  32'hFFFFFFFF, 1, idle0);
    add_row(CMD_RSVD_HI,             6'd63, 32'hFFFFFFFF, 1, idle0);
    add_row(isl_pkg::CMD_PUSH_BACK,  6'd0,  32'hFFFFFFFF, 1,
            outcome(1'b1, '0, 7'd1, 1'b0));
    add_row(isl_pkg::CMD_PUSH_FRONT, 6'd63, 32'h0,        1,
            outcome(1'b1, '0, 7'd2, 1'b0));
    add_row(isl_pkg::CMD_INSERT,     6'd63, 32'hA5A5A5A5, 0, none);
    add_row(isl_pkg::CMD_INSERT,     6'd1,  32'h12345678, 0, none);
    add_row(isl_pkg::CMD_INSERT,     6'd0,  32'h0F0F0F0F, 0, none);
    add_row(isl_pkg::CMD_READ,       6'd0,  32'h0,        0, none);
    add_row(isl_pkg::CMD_READ,       6'd4,  32'h0,        0, none);
    add_row(isl_pkg::CMD_READ,       6'd5,  32'h0,        1,
            outcome(1'b0, '0, 7'd5, 1'b0));
    add_row(isl_pkg::CMD_CHANGE,     6'd63, 32'hDEADBEEF, 1,
            outcome(1'b0, '0, 7'd5, 1'b0));
    add_row(isl_pkg::CMD_CHANGE,     6'd2,  32'h5A5A5A5A, 0, none);
    add_row(isl_pkg::CMD_ERASE,      6'd63, 32'h0,        0, none);
    add_row(isl_pkg::CMD_ERASE,      6'd0,  32'h0,        0, none);
    add_row(isl_pkg::CMD_FRONT,      6'd0,  32'h0,        0, none);
    add_row(isl_pkg::CMD_BACK,       6'd0,  32'h0,        0, none);
    add_row(CMD_RSVD_LO,             6'd0,  32'h0,        0, none);
    add_row(isl_pkg::CMD_CLEAR,      6'd0,  32'h0,        1,
            outcome(1'b1, '0, 7'd0, 1'b1));
    add_row(isl_pkg::CMD_CLEAR,      6'd0,  32'h0,        1,
            outcome(1'b1, '0, 7'd0, 1'b1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i])
      send_word(plan[i].cmd, plan[i].pos, plan[i].val, plan[i].typed, plan[i].exp,
                $urandom_range(0, 15));

    burst = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      ph = (n / PHASE_LEN) % 11;
      if (n % PHASE_LEN == 0) burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < add_pct[ph]) begin
        case ($urandom_range(0, 2))
          0:       c = isl_pkg::CMD_PUSH_BACK;
          1:       c = isl_pkg::CMD_PUSH_FRONT;
          default: c = isl_pkg::CMD_INSERT;
        endcase
      end else if (r < add_pct[ph] + del_pct[ph]) begin
        case ($urandom_range(0, 2))
          0:       c = isl_pkg::CMD_ERASE;
          1:       c = isl_pkg::CMD_POP_BACK;
          default: c = isl_pkg::CMD_POP_FRONT;
        endcase
      end else begin
        r = $urandom_range(0, 19);
        if (r < 6)       c = isl_pkg::CMD_READ;
        else if (r < 11) c = isl_pkg::CMD_CHANGE;
        else if (r < 14) c = isl_pkg::CMD_FRONT;
        else if (r < 17) c = isl_pkg::CMD_BACK;
        else if (r < 18) c = isl_pkg::CMD_CLEAR;
        else             c = 4'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
      end
      // aim half the indexes at the held range or one past its end, the rest anywhere
      if ($urandom_range(0, 1) == 0) p = 6'($urandom_range(0, 63));
      else p = 6'($urandom_range(0, (len_hint > 63) ? 63 : len_hint));
      gap = burst ? 0 : $urandom_range(0, 15);
      send_word(c, p, $urandom(), 1'b0, none, gap);
    end
    cmd_if.valid <= 1'b0;

    while (n_results < n_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_q.size());
      n_errors++;
    end
    $display("Ran %0d commands and checked %0d result words; the list peaked at %0d of %0d.",
             n_taken, n_results, peak_len, isl_pkg::DEPTH);
    $display("Rejections seen: %0d on a full list, %0d on an empty list; %0d mismatches.",
             n_full_rej, n_empty_rej, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/isl_pkg.sv
rtl/core/isl_if.sv
rtl/core/isl_cell.sv
rtl/core/indexed_shift_list_store.sv
dv/indexed_shift_list_store_tb.sv
